[design/fixed_step_catchup_pacer_assert.svh]
// Assertion macros shared by the pacer checker
`ifndef FIXED_STEP_CATCHUP_PACER_ASSERT_SVH
`define FIXED_STEP_CATCHUP_PACER_ASSERT_SVH

// check while out of reset
`define FSCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define FSCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/fscp_pkg.sv]
// Shared types and constants for the fixed-step catch-up pacer
package fscp_pkg;

    localparam int STEP_W  = 24;
    localparam int SPEED_W = 16;
    localparam int STAMP_W = 31;
    localparam int DELTA_W = 32;
    localparam int ACC_W   = 27;
    localparam int SCALE_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR = 1'b1;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd4267;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
    localparam logic [ACC_W-1:0]   ACC_MAX     = 27'h7FF_FFFF;

    typedef struct packed {
        logic load;
        logic clamp;
        logic sub;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic skip_frame;
        logic sub_more;
        logic out_free;
    } status_t;

endpackage

[design/fixed_step_catchup_pacer.sv]
// Fixed-step catch-up pacer top level.
// Sequence: timestamp accept, clamp, then n step subtractions, n the steps taken
// (0..MAX_CATCHUP), then the result register; a skipped frame skips the subtractions.
// A new timestamp is taken only once the last result is written; steps are taken at one
// step subtraction per cycle in the shared subtractor. A result waits in the output register.
// Reset: step_length 4267, speed_factor 256, pacing state cleared.
module fixed_step_catchup_pacer #(
    parameter int MAX_CATCHUP = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fscp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fscp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fscp_pkg::STAMP_W-1:0]        timestamp,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          update_count,
    output logic [fscp_pkg::SCALE_W-1:0]        scaled_step,
    output logic signed [fscp_pkg::DELTA_W-1:0] real_delta,
    output logic                                frame_skipped
);

    fscp_pkg::cmd_t    cmd;
    fscp_pkg::status_t status;

    fscp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fscp_datapath #(
        .MAX_CATCHUP (MAX_CATCHUP)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .timestamp     (timestamp),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .update_count  (update_count),
        .scaled_step   (scaled_step),
        .real_delta    (real_delta),
        .frame_skipped (frame_skipped)
    );

endmodule

[design/fscp_ctrl.sv]
// Controller state machine for the pacer
module fscp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fscp_pkg::status_t status,
    output fscp_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SUB,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = status.skip_frame ? ST_DONE : ST_SUB;
            end
            ST_SUB:
            begin
                if (status.sub_more)
                begin
                    cmd.sub = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/fscp_datapath.sv]
// Datapath for the pacer: config, delta, accumulator, step subtraction, result
module fscp_datapath #(
    parameter int MAX_CATCHUP = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fscp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fscp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [fscp_pkg::STAMP_W-1:0]       timestamp,
    input  fscp_pkg::cmd_t                     cmd,
    output fscp_pkg::status_t                  status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         update_count,
    output logic [fscp_pkg::SCALE_W-1:0]       scaled_step,
    output logic signed [fscp_pkg::DELTA_W-1:0] real_delta,
    output logic                               frame_skipped
);

    localparam int CNT_W = $clog2(MAX_CATCHUP + 1);
    localparam int LIM_W = fscp_pkg::STEP_W + CNT_W;
    localparam int SUM_W = ((LIM_W > fscp_pkg::ACC_W) ? LIM_W : fscp_pkg::ACC_W) + 1;
    localparam int ADD_W = fscp_pkg::STAMP_W + 8;
    localparam int PROD_W = fscp_pkg::STEP_W + fscp_pkg::SPEED_W;

    logic [fscp_pkg::STEP_W-1:0]  step_length_reg;
    logic [fscp_pkg::SPEED_W-1:0] speed_factor_reg;
    logic [fscp_pkg::STAMP_W-1:0] prev_stamp_reg;
    logic [fscp_pkg::DELTA_W-1:0] measured_delta_reg;
    logic [fscp_pkg::ACC_W-1:0]   acc_reg;
    logic [1:0]                   spiral_reg;
    logic [1:0]                   prev_count_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [CNT_W-1:0]             iter_reg;
    logic                         skipped_reg;
    logic [fscp_pkg::SCALE_W-1:0] scaled_reg;
    logic                         out_valid_reg;
    logic [1:0]                   update_count_reg;
    logic [fscp_pkg::SCALE_W-1:0] scaled_step_reg;
    logic [fscp_pkg::DELTA_W-1:0] real_delta_reg;
    logic                         frame_skipped_reg;

    logic [PROD_W-1:0]            product;
    logic [LIM_W-1:0]             limit;
    logic [ADD_W-1:0]             add_raw;
    logic [LIM_W-1:0]             add_clamped;
    logic [SUM_W-1:0]             sum_next;
    logic [fscp_pkg::ACC_W-1:0]   acc_sat;
    logic [1:0]                   cnt;
    logic [1:0]                   spiral_next;

    assign product = PROD_W'(step_length_reg) * PROD_W'(speed_factor_reg);
    assign limit   = LIM_W'(step_length_reg) * LIM_W'(MAX_CATCHUP);
    assign add_raw = {measured_delta_reg[fscp_pkg::STAMP_W-1:0], 8'b0};

    always_comb
    begin
        if (measured_delta_reg[fscp_pkg::DELTA_W-1])
        begin
            add_clamped = '0;
        end
        else if (add_raw > ADD_W'(limit))
        begin
            add_clamped = limit;
        end
        else
        begin
            add_clamped = add_raw[LIM_W-1:0];
        end
        if (step_length_reg == '0)
        begin
            sum_next = '0;
        end
        else
        begin
            sum_next = SUM_W'(acc_reg) + SUM_W'(add_clamped);
        end
    end

    always_comb
    begin
        if (sum_reg > SUM_W'(fscp_pkg::ACC_MAX))
        begin
            acc_sat = fscp_pkg::ACC_MAX;
        end
        else
        begin
            acc_sat = sum_reg[fscp_pkg::ACC_W-1:0];
        end
        if (32'(iter_reg) > 32'd3)
        begin
            cnt = 2'd3;
        end
        else
        begin
            cnt = 2'(iter_reg);
        end
        spiral_next = spiral_reg;
        if (cnt > prev_count_reg)
        begin
            if (spiral_reg != 2'd3)
            begin
                spiral_next = spiral_reg + 2'd1;
            end
        end
        else if (cnt < prev_count_reg)
        begin
            spiral_next = 2'd0;
        end
    end

    assign status.skip_frame = (spiral_reg > 2'd1);
    assign status.sub_more   = (iter_reg != CNT_W'(MAX_CATCHUP))
                               && (step_length_reg != '0)
                               && (sum_reg >= SUM_W'(step_length_reg));
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg    <= fscp_pkg::STEP_RESET;
            speed_factor_reg   <= fscp_pkg::SPEED_RESET;
            prev_stamp_reg     <= '0;
            measured_delta_reg <= '0;
            acc_reg            <= '0;
            spiral_reg         <= '0;
            prev_count_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fscp_pkg::REG_STEP_LENGTH:  step_length_reg  <= cfg_data;
                    fscp_pkg::REG_SPEED_FACTOR:
                        speed_factor_reg <= cfg_data[fscp_pkg::SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                if (prev_stamp_reg != '0)
                begin
                    measured_delta_reg <= fscp_pkg::DELTA_W'(timestamp)
                                        - fscp_pkg::DELTA_W'(prev_stamp_reg);
                end
                prev_stamp_reg <= timestamp;
            end
            if (cmd.clamp && status.skip_frame)
            begin
                acc_reg    <= '0;
                spiral_reg <= '0;
            end
            if (cmd.finish && !skipped_reg)
            begin
                acc_reg        <= acc_sat;
                spiral_reg     <= spiral_next;
                prev_count_reg <= cnt;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            scaled_reg <= product[PROD_W-1:8];
        end
        if (cmd.clamp)
        begin
            skipped_reg <= status.skip_frame;
            sum_reg     <= sum_next;
            iter_reg    <= '0;
        end
        if (cmd.sub)
        begin
            sum_reg  <= sum_reg - SUM_W'(step_length_reg);
            iter_reg <= iter_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            update_count_reg  <= skipped_reg ? 2'd0 : cnt;
            scaled_step_reg   <= scaled_reg;
            real_delta_reg    <= measured_delta_reg;
            frame_skipped_reg <= skipped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign update_count  = update_count_reg;
    assign scaled_step   = scaled_step_reg;
    assign real_delta    = real_delta_reg;
    assign frame_skipped = frame_skipped_reg;

endmodule

[design/fscp_checker.sv]
// Port-level checker for the pacer and its bind
`include "fixed_step_catchup_pacer_assert.svh"

module fscp_checker #(
    parameter int MAX_CATCHUP = 3
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [1:0]                          update_count,
    input logic [fscp_pkg::SCALE_W-1:0]        scaled_step,
    input logic signed [fscp_pkg::DELTA_W-1:0] real_delta,
    input logic                                frame_skipped
);

    property p_out_hold;
        out_valid && !out_ready |=> out_valid && $stable(update_count)
            && $stable(scaled_step) && $stable(real_delta) && $stable(frame_skipped);
    endproperty

    property p_skip_no_update;
        out_valid && frame_skipped |-> update_count == 2'd0;
    endproperty

    property p_one_at_a_time;
        in_valid && in_ready |=> !in_ready;
    endproperty

    property p_count_bound;
        out_valid |-> 32'(update_count) <= MAX_CATCHUP;
    endproperty

    property p_reset_quiet;
        !rst_n |=> !out_valid;
    endproperty

    `FSCP_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")
    `FSCP_ASSERT(a_skip_no_update, p_skip_no_update, "skipped frame reports updates")
    `FSCP_ASSERT(a_one_at_a_time, p_one_at_a_time, "new item taken while busy")
    `FSCP_ASSERT(a_count_bound, p_count_bound, "update count above catch-up bound")
    `FSCP_ASSERT_ALWAYS(a_reset_quiet, p_reset_quiet, "result valid during reset")

endmodule

bind fixed_step_catchup_pacer fscp_checker #(.MAX_CATCHUP(MAX_CATCHUP)) u_fscp_checker (.*);
